// ----- rtl/sip_pkg.sv -----
// Shared types and constants of the sorted interval partitioner.
package sip_pkg;

  // Field widths
  localparam int CHROM_W    = 16;
  localparam int COORD_W    = 32;
  localparam int CNT_W      = 32;
  localparam int REG_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ITEMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_DIST = 2'd1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input command codes
  localparam logic CMD_SPAN  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Kind of work handed from front to back
  typedef enum logic {
    OP_SPAN,
    OP_FLUSH
  } op_kind_t;

  // Input item
  typedef struct packed {
    logic               cmd;
    logic [CHROM_W-1:0] chrom_id;
    logic [COORD_W-1:0] range_start;
    logic [COORD_W-1:0] range_end;
  } src_item_t;

  // Result item
  typedef struct packed {
    logic               part_valid;
    logic [CHROM_W-1:0] part_chrom;
    logic [COORD_W-1:0] part_begin;
    logic [COORD_W-1:0] part_finish;
    logic [CNT_W-1:0]   part_items;
    logic [CNT_W-1:0]   part_number;
    logic [CNT_W-1:0]   total_items;
    logic [CNT_W-1:0]   min_items;
    logic [CNT_W-1:0]   max_items;
    logic               is_flush;
  } res_item_t;

  // Classified item held in the queue
  typedef struct packed {
    op_kind_t           kind;
    logic [CHROM_W-1:0] chrom_id;
    logic [COORD_W-1:0] range_start;
    logic [COORD_W-1:0] range_end;
  } op_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

endpackage

// ----- rtl/sip_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
module sip_front #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  sip_pkg::src_item_t  src_data,
  output sip_pkg::head_t      head,
  input  logic                pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sip_pkg::op_t     queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  sip_pkg::op_t     op_in;

  // Full queue holds the source off
  assign src_stall = (count == CNT_W'(DEPTH));
  assign push      = src_valid && !src_stall;

  // Classify: flush commands carry no coordinates
  always_comb begin
    op_in = '0;
    if (src_data.cmd == sip_pkg::CMD_FLUSH) begin
      op_in.kind = sip_pkg::OP_FLUSH;
    end else begin
      op_in.kind        = sip_pkg::OP_SPAN;
      op_in.chrom_id    = src_data.chrom_id;
      op_in.range_start = src_data.range_start;
      op_in.range_end   = src_data.range_end;
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = queue[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/sip_back.sv -----
// Back end: open partition, statistics, registers and the result register.
module sip_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sip_pkg::head_t                head,
  output logic                          pop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sip_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output sip_pkg::res_item_t            res_data
);

  logic [sip_pkg::REG_W-1:0]   min_items_per_part;
  logic [sip_pkg::REG_W-1:0]   merge_distance;

  logic                        open_valid;
  logic [sip_pkg::CHROM_W-1:0] open_chrom;
  logic [sip_pkg::COORD_W-1:0] open_start;
  logic [sip_pkg::COORD_W-1:0] open_end;
  logic [sip_pkg::CNT_W-1:0]   open_items;
  logic [sip_pkg::CNT_W-1:0]   closed_count;
  logic [sip_pkg::CNT_W-1:0]   sum_items;
  logic [sip_pkg::CNT_W-1:0]   least_items;
  logic [sip_pkg::CNT_W-1:0]   most_items;

  logic                        go;
  logic                        is_flush_op;
  logic                        same;
  logic                        overlap;
  logic                        few;
  logic                        near;
  logic                        join_open;
  logic                        closing;
  logic                        has_result;
  logic [sip_pkg::CNT_W:0]     sum_ext;
  logic [sip_pkg::CNT_W-1:0]   sum_next;
  logic [sip_pkg::CNT_W-1:0]   least_next;
  logic [sip_pkg::CNT_W-1:0]   most_next;
  logic [sip_pkg::CNT_W-1:0]   items_inc;
  logic [sip_pkg::CNT_W-1:0]   count_inc;
  logic [sip_pkg::COORD_W-1:0] gap;
  sip_pkg::res_item_t          res_next;

  assign cfg_ready = 1'b1;

  // Take the head whenever the result register is free or draining
  assign go          = head.valid && (!res_valid || !res_stall);
  assign pop         = go;
  assign is_flush_op = (head.op.kind == sip_pkg::OP_FLUSH);

  // Join test against the open partition
  assign same    = (head.op.chrom_id == open_chrom);
  assign overlap = (head.op.range_start < open_end) && (head.op.range_end > open_start);
  assign few     = (open_items < {1'b0, min_items_per_part});
  assign gap     = head.op.range_start - open_end;
  assign near    = (open_end < head.op.range_start)
                && (gap < sip_pkg::COORD_W'(merge_distance));
  assign join_open = open_valid && same && (overlap || few || near);

  assign closing    = open_valid && (is_flush_op || !join_open);
  assign has_result = is_flush_op || closing;

  // Statistics as they stand once the open partition closes
  assign sum_ext    = {1'b0, sum_items} + {1'b0, open_items};
  assign sum_next   = sum_ext[sip_pkg::CNT_W] ? sip_pkg::CNT_MAX
                                              : sum_ext[sip_pkg::CNT_W-1:0];
  assign least_next = (open_items < least_items) ? open_items : least_items;
  assign most_next  = (open_items > most_items) ? open_items : most_items;
  assign items_inc  = (open_items == sip_pkg::CNT_MAX) ? open_items : open_items + 1'b1;
  assign count_inc  = (closed_count == sip_pkg::CNT_MAX) ? closed_count
                                                         : closed_count + 1'b1;

  // Result contents
  always_comb begin
    res_next = '0;
    res_next.is_flush = is_flush_op;
    if (closing) begin
      res_next.part_valid  = 1'b1;
      res_next.part_chrom  = open_chrom;
      res_next.part_begin  = open_start;
      res_next.part_finish = open_end;
      res_next.part_items  = open_items;
      res_next.part_number = closed_count;
      res_next.total_items = sum_next;
      res_next.min_items   = least_next;
      res_next.max_items   = most_next;
    end else begin
      res_next.total_items = sum_items;
      res_next.min_items   = least_items;
      res_next.max_items   = most_items;
    end
  end

  // Control state, statistics and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_items_per_part <= '0;
      merge_distance     <= '0;
      open_valid         <= 1'b0;
      open_chrom         <= '0;
      open_start         <= '0;
      open_end           <= '0;
      open_items         <= '0;
      closed_count       <= '0;
      sum_items          <= '0;
      least_items        <= sip_pkg::CNT_MAX;
      most_items         <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sip_pkg::REG_MIN_ITEMS:  min_items_per_part <= cfg_data[sip_pkg::REG_W-1:0];
          sip_pkg::REG_MERGE_DIST: merge_distance     <= cfg_data[sip_pkg::REG_W-1:0];
          default: ;
        endcase
      end

      if (go && has_result) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      if (go) begin
        case (head.op.kind)
          sip_pkg::OP_FLUSH: begin
            open_valid   <= 1'b0;
            closed_count <= '0;
            sum_items    <= '0;
            least_items  <= sip_pkg::CNT_MAX;
            most_items   <= '0;
          end
          sip_pkg::OP_SPAN: begin
            if (join_open) begin
              if (head.op.range_start < open_start) begin
                open_start <= head.op.range_start;
              end
              if (head.op.range_end > open_end) begin
                open_end <= head.op.range_end;
              end
              open_items <= items_inc;
            end else begin
              if (open_valid) begin
                closed_count <= count_inc;
                sum_items    <= sum_next;
                least_items  <= least_next;
                most_items   <= most_next;
              end
              open_valid <= 1'b1;
              open_chrom <= head.op.chrom_id;
              open_start <= head.op.range_start;
              open_end   <= head.op.range_end;
              open_items <= sip_pkg::CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (go && has_result) begin
      res_data <= res_next;
    end
  end

  a_plain_close_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.is_flush |-> res_data.part_valid)
    else $error("partition result without a partition");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    go && is_flush_op |=> (sum_items == '0) && (closed_count == '0)
      && (least_items == sip_pkg::CNT_MAX) && (most_items == '0) && !open_valid)
    else $error("statistics not cleared after flush");

  a_open_nonzero: assert property (@(posedge clk) disable iff (rst)
    open_valid |-> (open_items != '0))
    else $error("open partition with no items");

endmodule

// ----- rtl/sorted_interval_partitioner_top.sv -----
// Sorted interval partitioner: top level joining front queue and back end.
//
// Use: sorted intervals enter on src_valid/src_stall with src_data
// (cmd 0 = interval, cmd 1 = end of data). Results leave on
// res_valid/res_stall with res_data; an interval that closes a partition
// gives one result, an end-of-data command always gives one (the open
// partition if any, plus the statistics, which are then cleared).
// Registers min_items_per_part (index 0) and merge_distance (index 1) are
// written on cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high. Write them only while the block is idle.
// Throughput: one item per cycle while res_stall does not hold the back
// end; each item gets one pass through the back end's compare and update
// logic. A result passes through the queue write and then the result
// register after its item is accepted.
// A stalled result holds in the result register while the back end stops;
// the QUEUE_DEPTH-entry queue keeps accepting until full, then src_stall
// rises. Synchronous reset empties the queue, closes the open partition
// and sets counts to zero, the minimum to all ones and both registers to 0.
module sorted_interval_partitioner_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  sip_pkg::src_item_t            src_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output sip_pkg::res_item_t            res_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sip_pkg::CFG_DATA_W-1:0] cfg_data
);

  sip_pkg::head_t head;
  logic           pop;

  sip_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .head      (head),
    .pop       (pop)
  );

  sip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
